// ===== design/fixed_partition_fit_allocator_assert.svh =====
// Assertion macros for the allocator file that checks its own logic.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define FPFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define FPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fpfa_pkg.sv =====
// Shared types and constants of the fixed partition fit allocator.
package fpfa_pkg;

	localparam int PARTITIONS = 16;
	localparam int SIZE_BITS  = 32;
	localparam int IDX_W      = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
	localparam int LIM_W      = ($clog2(PARTITIONS + 1) > 5) ? $clog2(PARTITIONS + 1) : 5;

	localparam int OP_W     = 2;
	localparam int SLOT_W   = 4;
	localparam int AMOUNT_W = 32;
	localparam int CHOSEN_W = 4;
	localparam int CFG_W    = 5;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_REQUEST = 2'd1,
		OP_CLEAR   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIT_MODE     = 1'd0,
		CFG_PARTS_IN_USE = 1'd1
	} cfg_idx_t;

endpackage

// ===== design/fpfa_if.sv =====
// Handshake channels of the allocator: request beats in, result beats out.
interface fpfa_in_if;
	import fpfa_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [SLOT_W-1:0]   slot;
	logic [AMOUNT_W-1:0] amount;

	modport source (output valid, output op, output slot, output amount, input ready);
	modport sink   (input valid, input op, input slot, input amount, output ready);
endinterface

interface fpfa_out_if;
	import fpfa_pkg::*;

	logic                valid;
	logic                ready;
	logic                granted;
	logic [CHOSEN_W-1:0] chosen;

	modport source (output valid, output granted, output chosen, input ready);
	modport sink   (input valid, input granted, input chosen, output ready);
endinterface

// ===== design/fpfa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module fpfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

// ===== design/fixed_partition_fit_allocator.sv =====
// Top level of the fixed partition allocator: size table, taken marks and fit scan.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+-------------------------------
//   in_ch    | in  | valid / ready  | op, slot, amount
//   out_ch   | out | valid / ready  | granted, chosen
//   cfg      | in  | cfg_we only    | cfg_idx, cfg_data
//
// A load or clear beat is absorbed in its accept cycle and gives no result.
// A request reads one partition per cycle through the registered size RAM port; with
// L = min(partitions_in_use, PARTITIONS) entries scanned, its result enters the output
// register once the scan ends, and in_ch is not ready until then.
// A finished scan that finds the output register full waits for out_ch to take it.
// Reset clears taken marks, registers and control state; sizes stay undefined until loaded.
`include "fixed_partition_fit_allocator_assert.svh"

module fixed_partition_fit_allocator (
	input  logic                               clk,
	input  logic                               arst_n,
	fpfa_in_if.sink                            in_ch,
	fpfa_out_if.source                         out_ch,
	input  logic                               cfg_we,
	input  logic [fpfa_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [fpfa_pkg::CFG_W-1:0]         cfg_data
);
	import fpfa_pkg::*;

	// The sequencer idles, scans the table, or holds a finished result
	// while the output register is still occupied.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

	state_t                state_q;
	logic [1:0]            fit_mode_q;
	logic [CFG_W-1:0]      piu_q;
	logic [PARTITIONS-1:0] taken_q;
	logic [LIM_W-1:0]      limit_q;
	logic [LIM_W-1:0]      cnt_q;
	logic [SIZE_BITS-1:0]  want_q;
	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [SIZE_BITS-1:0]  best_size_q;
	logic                  chk_vld_s1;
	logic [IDX_W-1:0]      chk_idx_s1;
	logic                  out_valid_q;
	logic                  out_granted_q;
	logic [CHOSEN_W-1:0]   out_chosen_q;

	logic                  in_fire;
	op_t                   in_op;
	logic                  slot_ok;
	logic                  load_we;
	logic [LIM_W-1:0]      piu_ext;
	logic [LIM_W-1:0]      limit_d;
	logic [SIZE_BITS-1:0]  rd_data;
	logic                  candidate;
	logic                  better;
	logic                  scan_more;
	logic                  scan_done;
	logic                  finishing;
	logic                  fin_fire;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign in_op       = op_t'(in_ch.op);

	assign slot_ok = LIM_W'(in_ch.slot) < LIM_W'(PARTITIONS);
	assign load_we = in_fire && (in_op == OP_LOAD) && slot_ok;

	// Entries beyond the table are never scanned.
	assign piu_ext = LIM_W'(piu_q);
	assign limit_d = (piu_ext > LIM_W'(PARTITIONS)) ? LIM_W'(PARTITIONS) : piu_ext;

	// The size table. Its read port follows the scan counter; the word for the
	// entry issued in one cycle arrives with chk_idx_s1 in the next.
	fpfa_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (PARTITIONS)
	) u_size_ram (
		.clk     (clk),
		.wr_en   (load_we),
		.wr_addr (IDX_W'(in_ch.slot)),
		.wr_data (SIZE_BITS'(in_ch.amount)),
		.rd_addr (cnt_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// The shared compare unit. A free entry large enough is a candidate; it
	// replaces the current pick only if it is the first one, or strictly
	// smaller (best fit) or strictly larger (worst fit), so ties keep the
	// lower index. First fit and the unused mode never replace a pick.
	assign candidate = chk_vld_s1 && !taken_q[chk_idx_s1] && (rd_data >= want_q);
	always_comb begin
		better = !found_q;
		unique case (fit_t'(fit_mode_q))
			FIT_BEST:  better = better || (rd_data < best_size_q);
			FIT_WORST: better = better || (rd_data > best_size_q);
			default:   better = !found_q;
		endcase
	end

	assign scan_more = (state_q == ST_SCAN) && (cnt_q < limit_q);
	assign scan_done = (state_q == ST_SCAN) && !scan_more && !chk_vld_s1;
	assign finishing = scan_done || (state_q == ST_HOLD);
	assign fin_fire  = finishing && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			fit_mode_q    <= '0;
			piu_q         <= '0;
			taken_q       <= '0;
			limit_q       <= '0;
			cnt_q         <= '0;
			want_q        <= '0;
			found_q       <= 1'b0;
			best_idx_q    <= '0;
			best_size_q   <= '0;
			chk_vld_s1    <= 1'b0;
			chk_idx_s1    <= '0;
			out_valid_q   <= 1'b0;
			out_granted_q <= 1'b0;
			out_chosen_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_idx))
					CFG_FIT_MODE:     fit_mode_q <= cfg_data[1:0];
					CFG_PARTS_IN_USE: piu_q      <= cfg_data;
				endcase
			end

			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			chk_vld_s1 <= scan_more;
			if (scan_more) begin
				chk_idx_s1 <= cnt_q[IDX_W-1:0];
				cnt_q      <= cnt_q + 1'b1;
			end

			if (candidate && better) begin
				found_q     <= 1'b1;
				best_idx_q  <= chk_idx_s1;
				best_size_q <= rd_data;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (in_op)
							OP_REQUEST: begin
								state_q <= ST_SCAN;
								want_q  <= SIZE_BITS'(in_ch.amount);
								limit_q <= limit_d;
								cnt_q   <= '0;
								found_q <= 1'b0;
							end
							OP_CLEAR: taken_q <= '0;
							default: ;
						endcase
					end
				end
				ST_SCAN, ST_HOLD: begin
					if (fin_fire) begin
						state_q       <= ST_IDLE;
						out_valid_q   <= 1'b1;
						out_granted_q <= found_q;
						out_chosen_q  <= found_q ? CHOSEN_W'(best_idx_q) : '0;
						if (found_q) begin
							taken_q[best_idx_q] <= 1'b1;
						end
					end else if (scan_done) begin
						state_q <= ST_HOLD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.granted = out_granted_q;
	assign out_ch.chosen  = out_chosen_q;

	// A granted partition is marked taken right after its result is issued.
	`FPFA_ASSERT_NEXT(a_grant_marks, fin_fire && found_q, taken_q[$past(best_idx_q)], "grant not marked taken")
	// A pick always lies inside the scanned range.
	`FPFA_ASSERT_NOW(a_pick_in_range, found_q && state_q != ST_IDLE, LIM_W'(best_idx_q) < limit_q, "pick outside scan range")
	// No compare is in flight while the sequencer is idle.
	`FPFA_ASSERT_NOW(a_idle_quiet, state_q == ST_IDLE, !chk_vld_s1, "compare in flight while idle")
	// A refused request reports index zero.
	`FPFA_ASSERT_NOW(a_refuse_zero, out_valid_q && !out_granted_q, out_chosen_q == '0, "refusal with nonzero index")
endmodule
